[hw/rtl/sfs_pkg.sv]
// Package for the sprite frame sequencer: field widths, register indexes,
// event and direction codes, and the configuration register struct.
// No dependencies.
package sfs_pkg;

	localparam int TICK_W     = 24;
	localparam int SUM_W      = TICK_W + 1;
	localparam int STEP_W     = 9;
	localparam int COUNT_W    = 9;
	localparam int POS_W      = 8;
	localparam int MAX_FRAMES = 256;
	localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_TOTAL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_RUNNING = 3'd4;

	localparam logic KIND_UPDATE  = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_END  = 2'd1;
	localparam logic [1:0] EV_LOOP = 2'd2;

	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_BWD  = 2'd2;

	typedef struct packed {
		logic [TICK_W-1:0]        frame_period;
		logic signed [STEP_W-1:0] step_size;
		logic [COUNT_W-1:0]       frame_total;
		logic                     loop_enable;
		logic                     start_running;
	} cfg_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] steps;
	} div_req_t;

endpackage

[hw/rtl/sfs_if.sv]
// Handshake interfaces of the sprite frame sequencer: command, result and
// configuration write channels. Depends on sfs_pkg.
interface sfs_cmd_if;
	import sfs_pkg::*;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [TICK_W-1:0] elapsed_ticks;
	modport source (output valid, kind, elapsed_ticks, input ready);
	modport sink (input valid, kind, elapsed_ticks, output ready);
endinterface

interface sfs_rsp_if;
	import sfs_pkg::*;
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] frame_now;
	logic             is_running;
	logic [1:0]       event_code;
	logic [1:0]       move_dir;
	modport source (output valid, frame_now, is_running, event_code, move_dir, input ready);
	modport sink (input valid, frame_now, is_running, event_code, move_dir, output ready);
endinterface

interface sfs_cfg_if;
	import sfs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wdata;
	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

[hw/rtl/sprite_frame_sequencer.sv]
// Top level of the sprite frame sequencer: sequencer over the shared divider.
// Depends on sfs_pkg, sfs_if, sfs_cfg and sfs_div.
//
//  Channel | Role   | Payload
//  cmd     | sink   | kind, elapsed_ticks
//  rsp     | source | frame_now, is_running, event_code, move_dir
//  cfg     | sink   | reg_index, wdata
//
// A restart or idle update goes to ST_FIN at once; it loads the result when the slot is free.
// A dividing update ends at the time divide if no frame changes; in one-shot mode, after D3.
// A looped update runs D3 through D6, preceded by D2 when the position must wrap into range.
// A divide takes one step per quotient bit; the time and D4 divides are longest at 25 steps.
// The reset clears the position, the residue and the running flag.
// A new command is taken while a result waits; its own result waits for the slot.
module sprite_frame_sequencer (
	input  logic     clk,
	input  logic     arst_n,
	sfs_cmd_if.sink  cmd,
	sfs_rsp_if.source rsp,
	sfs_cfg_if.sink  cfg
);
	import sfs_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_D1   = 3'd1;
	localparam logic [2:0] ST_D2   = 3'd2;
	localparam logic [2:0] ST_D3   = 3'd3;
	localparam logic [2:0] ST_D4   = 3'd4;
	localparam logic [2:0] ST_D5   = 3'd5;
	localparam logic [2:0] ST_D6   = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	cfg_t regs;

	logic [2:0]        state_q, state_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [TICK_W-1:0] residue_q, residue_d;
	logic              run_q, run_d;
	logic [1:0]        event_q, event_d;
	logic [1:0]        dir_q, dir_d;

	div_req_t          req_q;
	logic [SUM_W-1:0]  dvd_q;
	logic [TICK_W-1:0] dvs_q;
	logic              div_done;
	logic [SUM_W-1:0]  quo;
	logic [TICK_W-1:0] rem;

	logic                 launch;
	logic [SUM_W-1:0]     l_dvd;
	logic [TICK_W-1:0]    l_dvs;
	logic [DIV_CNT_W-1:0] l_steps;
	logic                 fin_load;

	logic [SUM_W-1:0] changes_q;
	logic [POS_W-1:0] cmod_q;
	logic             reached_q;

	logic             rsp_valid_q;
	logic [POS_W-1:0] rsp_frame_q;
	logic             rsp_run_q;
	logic [1:0]       rsp_event_q;
	logic [1:0]       rsp_dir_q;

	logic               cmd_acc;
	logic [COUNT_W-1:0] count;
	logic [POS_W-1:0]   last;
	logic [STEP_W-1:0]  step_u;
	logic [STEP_W-1:0]  mag;
	logic               fwd;
	logic [1:0]         dir_code;
	logic               idle_upd;
	logic [SUM_W-1:0]   total;
	logic [POS_W-1:0]   p_clamp;
	logic               need_mod;
	logic [POS_W-1:0]   p_sel;
	logic [POS_W-1:0]   d3_arg;
	logic [COUNT_W-1:0] until_n;
	logic               reached;
	logic [POS_W+STEP_W-1:0] os_delta;
	logic [POS_W-1:0]   step_pos;
	logic [2*POS_W-1:0] prod;
	logic [COUNT_W-1:0] wsum;
	logic [COUNT_W-1:0] wrapped;
	logic [POS_W-1:0]   restart_pos;

	sfs_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	sfs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_q),
		.dividend  (dvd_q),
		.divisor   (dvs_q),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc = cmd.valid && cmd.ready;

	assign count = (regs.frame_total > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES)
		: regs.frame_total;
	assign last = POS_W'(count - COUNT_W'(1));
	assign step_u = regs.step_size;
	assign mag = step_u[STEP_W-1] ? (~step_u + STEP_W'(1)) : step_u;
	assign fwd = (step_u != '0) && !step_u[STEP_W-1];
	assign dir_code = fwd ? DIR_FWD : DIR_BWD;
	assign idle_upd = !run_q || (regs.frame_period == '0) || (step_u == '0) || (count == '0);
	assign total = {1'b0, residue_q} + {1'b0, cmd.elapsed_ticks};
	assign restart_pos = (step_u[STEP_W-1] && (count != '0)) ? last : '0;

	assign p_clamp = (!regs.loop_enable && (pos_q > last)) ? last : pos_q;
	assign need_mod = regs.loop_enable && ({1'b0, pos_q} >= count);
	assign p_sel = (state_q == ST_D2) ? rem[POS_W-1:0] : p_clamp;
	assign d3_arg = fwd ? (last - p_sel) : p_sel;

	assign until_n = {1'b0, quo[POS_W-1:0]} + COUNT_W'(1);
	assign reached = changes_q >= SUM_W'(until_n);
	assign os_delta = (POS_W+STEP_W)'(changes_q[POS_W-1:0]) * (POS_W+STEP_W)'(mag);
	assign step_pos = fwd ? (pos_q + os_delta[POS_W-1:0]) : (pos_q - os_delta[POS_W-1:0]);
	assign prod = (2*POS_W)'(rem[POS_W-1:0]) * (2*POS_W)'(cmod_q);
	assign wsum = fwd ? ({1'b0, pos_q} + {1'b0, rem[POS_W-1:0]})
		: ({1'b0, pos_q} + (count - {1'b0, rem[POS_W-1:0]}));
	assign wrapped = (wsum >= count) ? (wsum - count) : wsum;

	always_comb begin
		state_d   = state_q;
		pos_d     = pos_q;
		residue_d = residue_q;
		run_d     = run_q;
		event_d   = event_q;
		dir_d     = dir_q;
		launch    = 1'b0;
		l_dvd     = '0;
		l_dvs     = '0;
		l_steps   = '0;
		fin_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					event_d = EV_NONE;
					dir_d   = DIR_NONE;
					if (cmd.kind == KIND_RESTART) begin
						residue_d = '0;
						run_d     = regs.start_running;
						pos_d     = restart_pos;
						state_d   = ST_FIN;
					end else if (idle_upd) begin
						state_d = ST_FIN;
					end else begin
						launch  = 1'b1;
						l_dvd   = total;
						l_dvs   = regs.frame_period;
						l_steps = DIV_CNT_W'(SUM_W);
						state_d = ST_D1;
					end
				end
			end
			ST_D1: begin
				if (div_done) begin
					residue_d = rem;
					if (quo == '0) begin
						state_d = ST_FIN;
					end else if (need_mod) begin
						launch  = 1'b1;
						l_dvd   = {pos_q, {(SUM_W-POS_W){1'b0}}};
						l_dvs   = TICK_W'(count);
						l_steps = DIV_CNT_W'(POS_W);
						state_d = ST_D2;
					end else begin
						pos_d   = p_sel;
						launch  = 1'b1;
						l_dvd   = {d3_arg, {(SUM_W-POS_W){1'b0}}};
						l_dvs   = TICK_W'(mag);
						l_steps = DIV_CNT_W'(POS_W);
						state_d = ST_D3;
					end
				end
			end
			ST_D2: begin
				if (div_done) begin
					pos_d   = p_sel;
					launch  = 1'b1;
					l_dvd   = {d3_arg, {(SUM_W-POS_W){1'b0}}};
					l_dvs   = TICK_W'(mag);
					l_steps = DIV_CNT_W'(POS_W);
					state_d = ST_D3;
				end
			end
			ST_D3: begin
				if (div_done) begin
					if (!regs.loop_enable) begin
						if (reached) begin
							pos_d     = fwd ? last : '0;
							residue_d = '0;
							run_d     = 1'b0;
							event_d   = EV_END;
							dir_d     = dir_code;
						end else begin
							pos_d = step_pos;
						end
						state_d = ST_FIN;
					end else begin
						launch  = 1'b1;
						l_dvd   = changes_q;
						l_dvs   = TICK_W'(count);
						l_steps = DIV_CNT_W'(SUM_W);
						state_d = ST_D4;
					end
				end
			end
			ST_D4: begin
				if (div_done) begin
					launch  = 1'b1;
					l_dvd   = {mag, {(SUM_W-STEP_W){1'b0}}};
					l_dvs   = TICK_W'(count);
					l_steps = DIV_CNT_W'(STEP_W);
					state_d = ST_D5;
				end
			end
			ST_D5: begin
				if (div_done) begin
					launch  = 1'b1;
					l_dvd   = {prod, {(SUM_W-2*POS_W){1'b0}}};
					l_dvs   = TICK_W'(count);
					l_steps = DIV_CNT_W'(2*POS_W);
					state_d = ST_D6;
				end
			end
			ST_D6: begin
				if (div_done) begin
					pos_d = wrapped[POS_W-1:0];
					if (reached_q) begin
						event_d = EV_LOOP;
						dir_d   = dir_code;
					end
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!rsp_valid_q || rsp.ready) begin
					fin_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			residue_q   <= '0;
			run_q       <= 1'b0;
			event_q     <= EV_NONE;
			dir_q       <= DIR_NONE;
			req_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pos_q       <= pos_d;
			residue_q   <= residue_d;
			run_q       <= run_d;
			event_q     <= event_d;
			dir_q       <= dir_d;
			req_q.start <= launch;
			req_q.steps <= l_steps;
			if (fin_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			dvd_q <= l_dvd;
			dvs_q <= l_dvs;
		end
		if ((state_q == ST_D1) && div_done) begin
			changes_q <= quo;
		end
		if ((state_q == ST_D3) && div_done) begin
			reached_q <= reached;
		end
		if ((state_q == ST_D4) && div_done) begin
			cmod_q <= rem[POS_W-1:0];
		end
		if (fin_load) begin
			rsp_frame_q <= pos_q;
			rsp_run_q   <= run_q;
			rsp_event_q <= event_q;
			rsp_dir_q   <= dir_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.frame_now  = rsp_frame_q;
	assign rsp.is_running = rsp_run_q;
	assign rsp.event_code = rsp_event_q;
	assign rsp.move_dir   = rsp_dir_q;

endmodule

[hw/rtl/sfs_cfg.sv]
// Configuration register file of the sprite frame sequencer.
// Depends on sfs_pkg and sfs_cfg_if.
module sfs_cfg (
	input  logic          clk,
	input  logic          arst_n,
	sfs_cfg_if.sink       cfg,
	output sfs_pkg::cfg_t regs
);
	import sfs_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.frame_period  <= '0;
			regs_q.step_size     <= STEP_W'(1);
			regs_q.frame_total   <= '0;
			regs_q.loop_enable   <= 1'b0;
			regs_q.start_running <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				REG_FRAME_PERIOD:  regs_q.frame_period  <= cfg.wdata[TICK_W-1:0];
				REG_STEP_SIZE:     regs_q.step_size     <= cfg.wdata[STEP_W-1:0];
				REG_FRAME_TOTAL:   regs_q.frame_total   <= cfg.wdata[COUNT_W-1:0];
				REG_LOOP_ENABLE:   regs_q.loop_enable   <= cfg.wdata[0];
				REG_START_RUNNING: regs_q.start_running <= cfg.wdata[0];
				default: begin
				end
			endcase
		end
	end

endmodule

[hw/rtl/sfs_div.sv]
// Shared restoring divider of the sprite frame sequencer, one quotient bit
// per cycle over a left-aligned dividend. Depends on sfs_pkg.
module sfs_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sfs_pkg::div_req_t         req,
	input  logic [sfs_pkg::SUM_W-1:0]  dividend,
	input  logic [sfs_pkg::TICK_W-1:0] divisor,
	output logic                      done,
	output logic [sfs_pkg::SUM_W-1:0]  quotient,
	output logic [sfs_pkg::TICK_W-1:0] remainder
);
	import sfs_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]     qr_q;
	logic [TICK_W-1:0]    r_q;
	logic [SUM_W-1:0]     trial;
	logic [SUM_W-1:0]     diff;
	logic                 fit;

	assign trial = {r_q, qr_q[SUM_W-1]};
	assign diff = trial - {1'b0, divisor};
	assign fit = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			qr_q <= dividend;
			r_q  <= '0;
		end else if (busy_q) begin
			qr_q <= {qr_q[SUM_W-2:0], fit};
			r_q  <= fit ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
		end
	end

	assign done = done_q;
	assign quotient = qr_q;
	assign remainder = r_q;

endmodule

[hw/rtl/sfs_port_chk.sv]
// Port-level assertions for the sprite frame sequencer and the bind that
// attaches them to the top level. Depends on sfs_pkg.
module sfs_port_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cmd_valid,
	input logic                      cmd_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic [sfs_pkg::POS_W-1:0] rsp_frame_now,
	input logic                      rsp_is_running,
	input logic [1:0]                rsp_event_code,
	input logic [1:0]                rsp_move_dir
);
	import sfs_pkg::*;

	// The block works on one command at a time.
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command channel ready right after a transaction");

	a_rsp_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_frame_now) && $stable(rsp_is_running)
			&& $stable(rsp_event_code) && $stable(rsp_move_dir))
		else $error("result payload changed while stalled");

	a_end_stops: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_event_code == EV_END) |-> !rsp_is_running)
		else $error("end event reported while still running");

	a_dir_only_with_event: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_event_code == EV_NONE) |-> (rsp_move_dir == DIR_NONE))
		else $error("direction reported without an event");

endmodule

bind sprite_frame_sequencer sfs_port_chk u_sfs_port_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_frame_now  (rsp.frame_now),
	.rsp_is_running (rsp.is_running),
	.rsp_event_code (rsp.event_code),
	.rsp_move_dir   (rsp.move_dir)
);

[bench/tb_top.sv]
// Testbench for sprite_frame_sequencer: drives commands and register writes,
// predicts every frame report and checks each one in order.
// Depends on sfs_pkg, sfs_if and the sequencer RTL.
`timescale 1ns / 1ps

module tb_top;
	import sfs_pkg::*;

	localparam int QUIET_LIMIT = 4000;

	typedef struct packed {
		logic [POS_W-1:0] frame_now;
		logic             is_running;
		logic [1:0]       event_code;
		logic [1:0]       move_dir;
	} frame_report_t;

	class frame_scoreboard;
		bit [TICK_W-1:0]          period;
		logic signed [STEP_W-1:0] step_val;
		bit [COUNT_W-1:0]         total;
		bit                       wrap;
		bit                       autostart;
		bit [POS_W-1:0]           frame;
		bit [TICK_W-1:0]          residue;
		bit                       running;
		frame_report_t            expected_reports[$];
		int                       errors;

		function new();
			period = '0;
			step_val = 9'sd1;
			total = '0;
			wrap = 1'b0;
			autostart = 1'b1;
			frame = '0;
			residue = '0;
			running = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_FRAME_PERIOD:  period = data[TICK_W-1:0];
				REG_STEP_SIZE:     step_val = data[STEP_W-1:0];
				REG_FRAME_TOTAL:   total = data[COUNT_W-1:0];
				REG_LOOP_ENABLE:   wrap = data[0];
				REG_START_RUNNING: autostart = data[0];
				default: ;
			endcase
		endfunction

		function frame_report_t advance_animation(logic cmd_kind, logic [TICK_W-1:0] ticks);
			frame_report_t     r;
			longint unsigned   cnt, tick_sum, changes, mag, last, pos, reach_at, delta;
			bit                fwd, reached;
			r.event_code = EV_NONE;
			r.move_dir = DIR_NONE;
			cnt = (total > MAX_FRAMES) ? MAX_FRAMES : total;
			fwd = (step_val > 0);
			mag = fwd ? longint'(step_val) : -longint'(step_val);
			if (cmd_kind == KIND_RESTART) begin
				residue = '0;
				running = autostart;
				frame = (step_val < 0 && cnt > 0) ? POS_W'(cnt - 1) : POS_W'(0);
			end else if (running && period != 0 && step_val != 0 && cnt != 0) begin
				tick_sum = longint'(residue) + longint'(ticks);
				changes = tick_sum / period;
				if (changes == 0) begin
					residue = TICK_W'(tick_sum);
				end else begin
					last = cnt - 1;
					pos = frame;
					if (wrap)
						pos = pos % cnt;
					else if (pos > last)
						pos = last;
					reach_at = fwd ? (last - pos) / mag + 1 : pos / mag + 1;
					reached = (changes >= reach_at);
					if (!wrap) begin
						if (reached) begin
							pos = fwd ? last : 0;
							residue = '0;
							running = 1'b0;
							r.event_code = EV_END;
							r.move_dir = fwd ? DIR_FWD : DIR_BWD;
						end else begin
							delta = changes * mag;
							pos = fwd ? pos + delta : pos - delta;
							residue = TICK_W'(tick_sum % period);
						end
					end else begin
						delta = ((mag % cnt) * (changes % cnt)) % cnt;
						pos = fwd ? (pos + delta) % cnt : (pos + cnt - delta) % cnt;
						residue = TICK_W'(tick_sum % period);
						if (reached) begin
							r.event_code = EV_LOOP;
							r.move_dir = fwd ? DIR_FWD : DIR_BWD;
						end
					end
					frame = POS_W'(pos);
				end
			end
			r.frame_now = frame;
			r.is_running = running;
			return r;
		endfunction

		function void note_command(logic cmd_kind, logic [TICK_W-1:0] ticks);
			expected_reports.push_back(advance_animation(cmd_kind, ticks));
		endfunction

		function void check_result(frame_report_t got);
			frame_report_t want;
			if (expected_reports.size() == 0) begin
				$display("%0t: report with no transaction waiting: frame_now %0d is_running %0d",
					$time, got.frame_now, got.is_running);
				errors++;
				return;
			end
			want = expected_reports.pop_front();
			if (got.frame_now !== want.frame_now) begin
				$display("%0t: frame_now expected %0d actual %0d", $time, want.frame_now,
					got.frame_now);
				errors++;
			end
			if (got.is_running !== want.is_running) begin
				$display("%0t: is_running expected %0d actual %0d", $time, want.is_running,
					got.is_running);
				errors++;
			end
			if (got.event_code !== want.event_code) begin
				$display("%0t: event_code expected %0d actual %0d", $time, want.event_code,
					got.event_code);
				errors++;
			end
			if (got.move_dir !== want.move_dir) begin
				$display("%0t: move_dir expected %0d actual %0d", $time, want.move_dir,
					got.move_dir);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	sfs_cmd_if cmd_ch();
	sfs_rsp_if rsp_ch();
	sfs_cfg_if cfg_ch();

	sprite_frame_sequencer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	frame_scoreboard sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	always #1 clk = ~clk;

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_result({rsp_ch.frame_now, rsp_ch.is_running, rsp_ch.event_code,
				rsp_ch.move_dir});
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
			$display("** sprite_frame_sequencer: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_cmd(input logic cmd_kind, input logic [TICK_W-1:0] ticks);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.kind <= cmd_kind;
		cmd_ch.elapsed_ticks <= ticks;
		do @(posedge clk); while (!cmd_ch.ready);
		sb.note_command(cmd_kind, ticks);
	endtask

	task automatic settle();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (sb.expected_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		settle();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wdata <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_phase(input int n_items, input int idle_pct, input int stall_pct);
		int                    i;
		int                    sv;
		int unsigned           span;
		logic [TICK_W-1:0]     ticks;
		logic [CFG_DATA_W-1:0] period_val, step_pat, total_val;
		case ($urandom_range(9))
			0: period_val = '0;
			1: period_val = 24'hFFFFFF;
			2: period_val = 24'd1;
			default: period_val = CFG_DATA_W'($urandom_range(1, 64));
		endcase
		sv = int'($urandom_range(0, 8)) - 4;
		case ($urandom_range(7))
			0: step_pat = 24'h100;
			1: step_pat = 24'd255;
			2: step_pat = 24'h101;
			3: step_pat = CFG_DATA_W'($urandom_range(0, 511));
			default: step_pat = {15'd0, sv[STEP_W-1:0]};
		endcase
		case ($urandom_range(7))
			0: total_val = 24'd0;
			1: total_val = 24'd1;
			2: total_val = 24'd256;
			3: total_val = CFG_DATA_W'($urandom_range(257, 511));
			default: total_val = CFG_DATA_W'($urandom_range(2, 40));
		endcase
		write_reg(REG_FRAME_PERIOD, period_val);
		write_reg(REG_STEP_SIZE, step_pat);
		write_reg(REG_FRAME_TOTAL, total_val);
		write_reg(REG_LOOP_ENABLE, 24'($urandom_range(1)));
		write_reg(REG_START_RUNNING, 24'($urandom_range(4) != 0));
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		if ($urandom_range(1))
			send_cmd(KIND_RESTART, TICK_W'($urandom()));
		for (i = 0; i < n_items; i++) begin
			if ($urandom_range(99) < 4 || (!sb.running && $urandom_range(99) < 40)) begin
				send_cmd(KIND_RESTART, TICK_W'($urandom()));
			end else begin
				case ($urandom_range(9))
					0: ticks = TICK_W'($urandom());
					1: ticks = '0;
					default: begin
						span = (sb.period == 0) ? 100 : int'(sb.period) * 3;
						if (span > 32'hFFFFFF)
							span = 32'hFFFFFF;
						ticks = TICK_W'($urandom_range(0, span));
					end
				endcase
				send_cmd(KIND_UPDATE, ticks);
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		int p;
		sb = new();
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.kind = KIND_UPDATE;
		cmd_ch.elapsed_ticks = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.reg_index = '0;
		cfg_ch.wdata = '0;
		rsp_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings leave the animation stopped with no frames.
		send_cmd(KIND_UPDATE, 24'd0);
		send_cmd(KIND_UPDATE, 24'hFFFFFF);
		send_cmd(KIND_RESTART, 24'hFFFFFF);
		write_reg(REG_FRAME_PERIOD, 24'd10);
		write_reg(REG_FRAME_TOTAL, 24'd5);
		send_cmd(KIND_UPDATE, 24'd9);
		send_cmd(KIND_UPDATE, 24'd1);
		send_cmd(KIND_UPDATE, 24'hFFFFFF);
		send_cmd(KIND_UPDATE, 24'd10);
		write_reg(REG_STEP_SIZE, 24'h1FF);
		send_cmd(KIND_RESTART, 24'd0);
		send_cmd(KIND_UPDATE, 24'd25);
		send_cmd(KIND_UPDATE, 24'd25);
		write_reg(REG_LOOP_ENABLE, 24'd1);
		write_reg(REG_STEP_SIZE, 24'd3);
		write_reg(REG_FRAME_TOTAL, 24'd7);
		send_cmd(KIND_RESTART, 24'd0);
		send_cmd(KIND_UPDATE, 24'd30);
		write_reg(REG_STEP_SIZE, 24'h100);
		write_reg(REG_FRAME_TOTAL, 24'd511);
		write_reg(REG_FRAME_PERIOD, 24'd1);
		send_cmd(KIND_RESTART, 24'd0);
		send_cmd(KIND_UPDATE, 24'hFFFFFF);
		write_reg(REG_STEP_SIZE, 24'd255);
		write_reg(REG_FRAME_PERIOD, 24'hFFFFFF);
		send_cmd(KIND_UPDATE, 24'hFFFFFF);
		send_cmd(KIND_UPDATE, 24'hFFFFFF);
		// A smaller frame count leaves the position beyond the last frame.
		write_reg(REG_LOOP_ENABLE, 24'd0);
		write_reg(REG_STEP_SIZE, 24'd1);
		write_reg(REG_FRAME_PERIOD, 24'd1);
		write_reg(REG_FRAME_TOTAL, 24'd256);
		send_cmd(KIND_RESTART, 24'd0);
		send_cmd(KIND_UPDATE, 24'd200);
		write_reg(REG_FRAME_TOTAL, 24'd10);
		send_cmd(KIND_UPDATE, 24'd1);
		write_reg(REG_FRAME_TOTAL, 24'd256);
		write_reg(REG_LOOP_ENABLE, 24'd1);
		send_cmd(KIND_RESTART, 24'd0);
		send_cmd(KIND_UPDATE, 24'd200);
		write_reg(REG_FRAME_TOTAL, 24'd7);
		send_cmd(KIND_UPDATE, 24'd3);
		write_reg(REG_STEP_SIZE, 24'd0);
		send_cmd(KIND_UPDATE, 24'd5);
		write_reg(REG_START_RUNNING, 24'd0);
		write_reg(REG_STEP_SIZE, 24'h101);
		send_cmd(KIND_RESTART, 24'd0);
		write_reg(REG_FRAME_TOTAL, 24'd0);
		write_reg(REG_START_RUNNING, 24'd1);
		send_cmd(KIND_RESTART, 24'd0);
		send_cmd(KIND_UPDATE, 24'd7);

		for (p = 0; p < 8; p++) begin
			case (p % 4)
				0: run_phase(235, 0, 0);
				1: run_phase(235, 66, 0);
				2: run_phase(235, 0, 66);
				default: run_phase(235, 34, 34);
			endcase
		end

		settle();
		repeat (120) @(posedge clk);
		if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
			$display("** sprite_frame_sequencer: PASSED **");
		end else begin
			$display("** sprite_frame_sequencer: FAILED **");
		end
		$finish;
	end

endmodule
